// ===== rtl/ffra_pkg.sv =====
// ============================================================================
// ffra_pkg: shared types and constants of the first-fit region allocator
// Field widths, operation and status codes, the table entry layout and the
// sequencer states used by all allocator files.
// ============================================================================
package ffra_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int ADDR_W     = 64;
    localparam int PAGES_W    = 31;
    localparam int STATUS_W   = 3;
    localparam int BYTES_W    = 32;
    localparam int IMAGE_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int OP_W       = 2;

    localparam int S_TDATA_W  = BYTES_W + ADDR_W;
    localparam int M_FIELDS_W = ADDR_W + PAGES_W + STATUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Pages are 4 KiB.
    localparam int PAGE_SHIFT = 12;
    localparam logic [ADDR_W-1:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;
    localparam logic [ADDR_W-1:0] HEAP_BASE = 64'hFFFF_FFFF_8000_0000;
    // Base plus the rounding bias, so the heap start needs only one add.
    localparam logic [ADDR_W-1:0] INIT_BIAS = HEAP_BASE + PAGE_MASK;

    localparam logic [PAGES_W-1:0] HEAP_PAGES_RST = 31'd262144;

    typedef enum logic [OP_W-1:0] {
        OP_INIT,
        OP_ALLOC,
        OP_FREE,
        OP_NONE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_SPACE,
        ST_TABLE_FULL,
        ST_NOT_FOUND,
        ST_BELOW_HEAP,
        ST_ZERO_REQ
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_SIZE,
        REG_HEAP_PAGES
    } cfg_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [PAGES_W-1:0] size;
        logic               free;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [IMAGE_W-1:0] image_size;
        logic [PAGES_W-1:0] heap_pages;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_ALLOC_FIT,
        S_ALLOC_SPLIT,
        S_ALLOC_MARK,
        S_FREE_MARK,
        S_RESP
    } state_t;

endpackage

// ===== rtl/first_fit_region_allocator.sv =====
// ============================================================================
// first_fit_region_allocator: first-fit page allocator over a region table
// Configuration registers, region table RAM and the scanning sequencer.
// ============================================================================
// One item is taken at a time. An init item writes the first table entry.
// An allocate or free item reads the region table through the single RAM
// read port, one entry per cycle, up to the first hit or the entry count.
// A free hit marks the entry free. An allocate hit reports a full table when
// a split is due and no entry is left, else writes any split remainder and
// marks the entry used. Zero-byte allocates, frees below the heap and unknown
// operations go straight to the result. The next item is accepted as soon as
// a result sits in the output register, even if it has not been taken yet.
// The table needs no clearing after reset: only entries below the entry count
// are ever read.
module first_fit_region_allocator #(
    parameter int TABLE_ENTRIES = ffra_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata, from bit 0: request_bytes[31:0], address[63:0]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ffra_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: operation[1:0]
    input  logic [ffra_pkg::OP_W-1:0]          s_tuser,
    // m_tdata, from bit 0: region_address[63:0], region_pages[30:0],
    // status[2:0], zero padding
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ffra_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [ffra_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ffra_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [ffra_pkg::IMAGE_W-1:0] image_size_reg, image_size_next;
    logic [ffra_pkg::PAGES_W-1:0] heap_pages_reg, heap_pages_next;
    ffra_pkg::cfg_t               cfg;

    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    ffra_pkg::entry_t  ram_wr_data;
    logic [IDX_W-1:0]  ram_rd_addr;
    ffra_pkg::entry_t  ram_rd_data;

    always_comb begin
        image_size_next = image_size_reg;
        heap_pages_next = heap_pages_reg;
        if (cfg_wr_en) begin
            case (ffra_pkg::cfg_reg_t'(cfg_addr))
                ffra_pkg::REG_IMAGE_SIZE: begin
                    image_size_next = cfg_wr_data[ffra_pkg::IMAGE_W-1:0];
                end
                ffra_pkg::REG_HEAP_PAGES: begin
                    heap_pages_next = cfg_wr_data[ffra_pkg::PAGES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg <= '0;
            heap_pages_reg <= ffra_pkg::HEAP_PAGES_RST;
        end else begin
            image_size_reg <= image_size_next;
            heap_pages_reg <= heap_pages_next;
        end
    end

    assign cfg = '{image_size: image_size_reg, heap_pages: heap_pages_reg};

    ffra_ram #(
        .WIDTH (ffra_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ffra_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // An accepted item keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input accepted in the cycle after a transfer");

    // A failed request reports neither an address nor a page count.
    a_fail_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[97:95] != ffra_pkg::ST_OK))
            |-> ((m_tdata[63:0] == '0) && (m_tdata[94:64] == '0))
    ) else $error("failed result carries a region");

    // Reset leaves no result pending.
    a_reset_empty: assert property (
        @(posedge aclk)
        !aresetn |=> !m_tvalid
    ) else $error("result valid after reset");

endmodule

// ===== rtl/ffra_ram.sv =====
// ============================================================================
// ffra_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ============================================================================
module ffra_ram #(
    parameter int WIDTH = ffra_pkg::ENTRY_W,
    parameter int DEPTH = ffra_pkg::TABLE_ENTRIES_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ffra_match.sv =====
// ============================================================================
// ffra_match: shared entry compare unit
// Tests one table entry per cycle: fit test for allocate, start-address
// match for free.
// ============================================================================
module ffra_match (
    input  ffra_pkg::op_t                   op,
    input  ffra_pkg::entry_t                entry,
    input  logic [ffra_pkg::PAGES_W-1:0]    pages,
    input  logic [ffra_pkg::ADDR_W-1:0]     addr,
    output logic                            hit
);

    always_comb begin
        case (op)
            ffra_pkg::OP_ALLOC: begin
                hit = entry.free && (entry.size >= pages);
            end
            ffra_pkg::OP_FREE: begin
                hit = (entry.start == addr);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/ffra_seq.sv =====
// ============================================================================
// ffra_seq: allocator sequencer
// Walks the region table through the RAM read port one entry per cycle,
// feeds the compare unit, then updates the table and forms the result.
// ============================================================================
module ffra_seq #(
    parameter int TABLE_ENTRIES = ffra_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(TABLE_ENTRIES),
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ffra_pkg::cfg_t                    cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ffra_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [ffra_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ffra_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              ram_wr_en,
    output logic [IDX_W-1:0]                  ram_wr_addr,
    output ffra_pkg::entry_t                  ram_wr_data,
    output logic [IDX_W-1:0]                  ram_rd_addr,
    input  ffra_pkg::entry_t                  ram_rd_data
);

    localparam int SUM_W = ffra_pkg::BYTES_W + 1;

    ffra_pkg::state_t  state_reg, state_next;
    ffra_pkg::op_t     op_reg, op_next;
    logic [ffra_pkg::PAGES_W-1:0]  pages_reg, pages_next;
    logic [ffra_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [ffra_pkg::ADDR_W-1:0]   heap_start_reg, heap_start_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]              chk_idx_reg, chk_idx_next;
    logic                          pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]              hit_idx_reg, hit_idx_next;
    ffra_pkg::entry_t              hit_reg, hit_next;
    logic [ffra_pkg::PAGES_W-1:0]  rest_reg, rest_next;
    logic [ffra_pkg::ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [ffra_pkg::PAGES_W-1:0]  res_pages_reg, res_pages_next;
    ffra_pkg::status_t             res_status_reg, res_status_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [ffra_pkg::ADDR_W-1:0]   m_addr_reg, m_addr_next;
    logic [ffra_pkg::PAGES_W-1:0]  m_pages_reg, m_pages_next;
    ffra_pkg::status_t             m_status_reg, m_status_next;

    logic [ffra_pkg::BYTES_W-1:0]  s_bytes;
    logic [ffra_pkg::ADDR_W-1:0]   s_address;
    ffra_pkg::op_t                 s_op;
    logic [SUM_W-1:0]              pages_sum;
    logic [SUM_W-1:0]              pages_calc;
    logic [ffra_pkg::ADDR_W-1:0]   init_start;
    logic                          issue;
    logic                          match_hit;

    assign s_bytes   = s_tdata[ffra_pkg::BYTES_W-1:0];
    assign s_address = s_tdata[ffra_pkg::S_TDATA_W-1:ffra_pkg::BYTES_W];
    assign s_op      = ffra_pkg::op_t'(s_tuser);

    // Round the byte count up to whole pages.
    assign pages_sum  = {1'b0, s_bytes} + SUM_W'(ffra_pkg::PAGE_MASK);
    assign pages_calc = pages_sum >> ffra_pkg::PAGE_SHIFT;

    assign init_start = (ffra_pkg::INIT_BIAS + ffra_pkg::ADDR_W'(cfg.image_size))
                        & ~ffra_pkg::PAGE_MASK;

    assign ram_rd_addr = rd_idx_reg[IDX_W-1:0];

    ffra_match u_match (
        .op    (op_reg),
        .entry (ram_rd_data),
        .pages (pages_reg),
        .addr  (addr_reg),
        .hit   (match_hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ffra_pkg::S_IDLE;
            heap_start_reg <= '0;
            count_reg      <= '0;
            pipe_vld_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            heap_start_reg <= heap_start_next;
            count_reg      <= count_next;
            pipe_vld_reg   <= pipe_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pages_reg      <= pages_next;
        addr_reg       <= addr_next;
        rd_idx_reg     <= rd_idx_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_reg        <= hit_next;
        rest_reg       <= rest_next;
        res_addr_reg   <= res_addr_next;
        res_pages_reg  <= res_pages_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_pages_reg    <= m_pages_next;
        m_status_reg   <= m_status_next;
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        pages_next      = pages_reg;
        addr_next       = addr_reg;
        heap_start_next = heap_start_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        pipe_vld_next   = pipe_vld_reg;
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        rest_next       = rest_reg;
        res_addr_next   = res_addr_reg;
        res_pages_next  = res_pages_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_addr_next     = m_addr_reg;
        m_pages_next    = m_pages_reg;
        m_status_next   = m_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = hit_idx_reg;
        ram_wr_data     = hit_reg;
        issue           = 1'b0;
        s_tready        = (state_reg == ffra_pkg::S_IDLE);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ffra_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_op;
                    pages_next      = pages_calc[ffra_pkg::PAGES_W-1:0];
                    addr_next       = s_address;
                    rd_idx_next     = '0;
                    pipe_vld_next   = 1'b0;
                    res_addr_next   = '0;
                    res_pages_next  = '0;
                    res_status_next = ffra_pkg::ST_OK;
                    case (s_op)
                        ffra_pkg::OP_INIT: begin
                            state_next = ffra_pkg::S_INIT;
                        end
                        ffra_pkg::OP_ALLOC: begin
                            if (s_bytes == '0) begin
                                res_status_next = ffra_pkg::ST_ZERO_REQ;
                                state_next      = ffra_pkg::S_RESP;
                            end else begin
                                state_next = ffra_pkg::S_SCAN;
                            end
                        end
                        ffra_pkg::OP_FREE: begin
                            if (s_address < heap_start_reg) begin
                                res_status_next = ffra_pkg::ST_BELOW_HEAP;
                                state_next      = ffra_pkg::S_RESP;
                            end else begin
                                state_next = ffra_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            state_next = ffra_pkg::S_RESP;
                        end
                    endcase
                end
            end
            ffra_pkg::S_INIT: begin
                heap_start_next = init_start;
                count_next      = CNT_W'(1);
                ram_wr_en       = 1'b1;
                ram_wr_addr     = '0;
                ram_wr_data     = '{start: init_start, size: cfg.heap_pages, free: 1'b1};
                res_addr_next   = init_start;
                res_pages_next  = cfg.heap_pages;
                state_next      = ffra_pkg::S_RESP;
            end
            ffra_pkg::S_SCAN: begin
                // Each read is issued in the cycle before its entry is compared; an entry read
                // past the hit is simply dropped.
                issue         = (rd_idx_reg < count_reg);
                rd_idx_next   = rd_idx_reg + CNT_W'(issue);
                pipe_vld_next = issue;
                chk_idx_next  = rd_idx_reg[IDX_W-1:0];
                if (pipe_vld_reg && match_hit) begin
                    hit_idx_next = chk_idx_reg;
                    hit_next     = ram_rd_data;
                    if (op_reg == ffra_pkg::OP_ALLOC) begin
                        state_next = ffra_pkg::S_ALLOC_FIT;
                    end else begin
                        state_next = ffra_pkg::S_FREE_MARK;
                    end
                end else if (!pipe_vld_reg && !issue) begin
                    if (op_reg == ffra_pkg::OP_ALLOC) begin
                        res_status_next = ffra_pkg::ST_NO_SPACE;
                    end else begin
                        res_status_next = ffra_pkg::ST_NOT_FOUND;
                    end
                    state_next = ffra_pkg::S_RESP;
                end
            end
            ffra_pkg::S_ALLOC_FIT: begin
                rest_next = hit_reg.size - pages_reg;
                if (rest_next == '0) begin
                    state_next = ffra_pkg::S_ALLOC_MARK;
                end else if (count_reg == CNT_W'(TABLE_ENTRIES)) begin
                    res_status_next = ffra_pkg::ST_TABLE_FULL;
                    state_next      = ffra_pkg::S_RESP;
                end else begin
                    state_next = ffra_pkg::S_ALLOC_SPLIT;
                end
            end
            ffra_pkg::S_ALLOC_SPLIT: begin
                // The remainder goes to a new free entry at the end of the table.
                ram_wr_en   = 1'b1;
                ram_wr_addr = count_reg[IDX_W-1:0];
                ram_wr_data = '{
                    start: hit_reg.start
                           + (ffra_pkg::ADDR_W'(pages_reg) << ffra_pkg::PAGE_SHIFT),
                    size:  rest_reg,
                    free:  1'b1
                };
                count_next  = count_reg + CNT_W'(1);
                state_next  = ffra_pkg::S_ALLOC_MARK;
            end
            ffra_pkg::S_ALLOC_MARK: begin
                ram_wr_en      = 1'b1;
                ram_wr_data    = '{start: hit_reg.start, size: pages_reg, free: 1'b0};
                res_addr_next  = hit_reg.start;
                res_pages_next = pages_reg;
                state_next     = ffra_pkg::S_RESP;
            end
            ffra_pkg::S_FREE_MARK: begin
                ram_wr_en      = 1'b1;
                ram_wr_data    = '{start: hit_reg.start, size: hit_reg.size, free: 1'b1};
                res_addr_next  = hit_reg.start;
                res_pages_next = hit_reg.size;
                state_next     = ffra_pkg::S_RESP;
            end
            ffra_pkg::S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_pages_next  = res_pages_reg;
                    m_status_next = res_status_reg;
                    state_next    = ffra_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ffra_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{ffra_pkg::M_PAD_W{1'b0}}, m_status_reg, m_pages_reg, m_addr_reg};

endmodule

// ===== tb/sv/first_fit_region_allocator_tb.sv =====
// ============================================================================
// first_fit_region_allocator_tb: self-checking bench for the region allocator
// Drives init, allocate and free requests over the input stream and checks
// every result against a table model kept inside the bench. It covers the
// empty-table and boundary cases, a long output hold-off, and randomized
// request mixes under several idle patterns and configurations.
// ============================================================================
module first_fit_region_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH = ffra_pkg::TABLE_ENTRIES_DEF;
    localparam logic [63:0] PAGE_BYTES  = 64'd1 << ffra_pkg::PAGE_SHIFT;
    localparam logic [63:0] HEAP_ORIGIN = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          HOLD_CYCLES = 400;

    typedef struct {
        logic [63:0]       addr;
        logic [30:0]       pages;
        ffra_pkg::status_t status;
    } region_result_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [ffra_pkg::S_TDATA_W-1:0]   s_tdata;
    logic [ffra_pkg::OP_W-1:0]        s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [ffra_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_wr_en;
    logic [ffra_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [ffra_pkg::CFG_DATA_W-1:0]  cfg_wr_data;

    // Table model of the allocator.
    logic [63:0] tbl_start [TABLE_DEPTH];
    logic [30:0] tbl_pages [TABLE_DEPTH];
    bit          tbl_free  [TABLE_DEPTH];
    int          tbl_count;
    logic [63:0] heap_base_addr;
    logic [31:0] cfg_image;
    logic [30:0] cfg_heap_pages;

    region_result_t expected_regions[$];

    event hold_off_ev;
    logic hold_active = 1'b0;

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int requests_sent;
    int results_checked;
    int status_seen [6];

    first_fit_region_allocator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic region_result_t predict_region_op(ffra_pkg::op_t op,
                                                         logic [31:0] bytes,
                                                         logic [63:0] addr);
        region_result_t res;
        logic [63:0]    want;
        logic [63:0]    rest;
        logic [63:0]    x;
        int             hit;
        res = '{64'd0, 31'd0, ffra_pkg::ST_OK};
        hit = -1;
        case (op)
            ffra_pkg::OP_INIT: begin
                x = HEAP_ORIGIN + {32'd0, cfg_image};
                if (x % PAGE_BYTES != 64'd0)
                    x = x + PAGE_BYTES - x % PAGE_BYTES;
                heap_base_addr = x;
                tbl_start[0] = x;
                tbl_pages[0] = cfg_heap_pages;
                tbl_free[0] = 1'b1;
                tbl_count = 1;
                res = '{x, cfg_heap_pages, ffra_pkg::ST_OK};
            end
            ffra_pkg::OP_ALLOC: begin
                want = ({32'd0, bytes} + PAGE_BYTES - 64'd1) / PAGE_BYTES;
                if (want == 64'd0) begin
                    res.status = ffra_pkg::ST_ZERO_REQ;
                end else begin
                    for (int i = 0; i < tbl_count; i++) begin
                        if (tbl_free[i] && {33'd0, tbl_pages[i]} >= want) begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit < 0) begin
                        res.status = ffra_pkg::ST_NO_SPACE;
                    end else begin
                        rest = {33'd0, tbl_pages[hit]} - want;
                        if (rest != 64'd0 && tbl_count >= TABLE_DEPTH) begin
                            res.status = ffra_pkg::ST_TABLE_FULL;
                        end else begin
                            // The remainder of a split goes to the end of the table.
                            if (rest != 64'd0) begin
                                tbl_start[tbl_count] = tbl_start[hit] + want * PAGE_BYTES;
                                tbl_pages[tbl_count] = rest[30:0];
                                tbl_free[tbl_count] = 1'b1;
                                tbl_count++;
                            end
                            tbl_pages[hit] = want[30:0];
                            tbl_free[hit] = 1'b0;
                            res = '{tbl_start[hit], want[30:0], ffra_pkg::ST_OK};
                        end
                    end
                end
            end
            ffra_pkg::OP_FREE: begin
                if (addr < heap_base_addr) begin
                    res.status = ffra_pkg::ST_BELOW_HEAP;
                end else begin
                    for (int i = 0; i < tbl_count; i++) begin
                        if (tbl_start[i] == addr) begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit < 0) begin
                        res.status = ffra_pkg::ST_NOT_FOUND;
                    end else begin
                        tbl_free[hit] = 1'b1;
                        res = '{addr, tbl_pages[hit], ffra_pkg::ST_OK};
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offers one request and records its expected result once the transfer
    // has taken place. Valid stays high between back-to-back requests.
    task automatic issue_request(ffra_pkg::op_t op, logic [31:0] bytes,
                                 logic [63:0] addr);
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {addr, bytes};
        do @(posedge aclk); while (!s_tready);
        expected_regions.push_back(predict_region_op(op, bytes, addr));
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_regions.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(ffra_pkg::cfg_reg_t idx, logic [31:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == ffra_pkg::REG_IMAGE_SIZE)
            cfg_image = value;
        else
            cfg_heap_pages = value[30:0];
    endtask

    // Result checker: compares each transfer with the oldest expectation.
    always @(posedge aclk) begin
        region_result_t want;
        logic [63:0]    got_addr;
        logic [30:0]    got_pages;
        logic [2:0]     got_status;
        if (aresetn && m_tvalid && m_tready) begin
            got_addr   = m_tdata[63:0];
            got_pages  = m_tdata[94:64];
            got_status = m_tdata[97:95];
            results_checked++;
            if (got_status <= ffra_pkg::ST_ZERO_REQ)
                status_seen[got_status]++;
            if (expected_regions.size() == 0) begin
                $error("unexpected result transfer: address %h pages %0d status %0d",
                       got_addr, got_pages, got_status);
                fail_count++;
            end else begin
                want = expected_regions.pop_front();
                if (got_addr !== want.addr) begin
                    $error("region_address: expected %h, got %h", want.addr, got_addr);
                    fail_count++;
                end
                if (got_pages !== want.pages) begin
                    $error("region_pages: expected %0d, got %0d", want.pages, got_pages);
                    fail_count++;
                end
                if (got_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got_status);
                    fail_count++;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once a test asks for it.
    initial begin
        forever begin
            @(hold_off_ev);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    // Output side: random stalls plus the optional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_active) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    task automatic test_before_init();
        issue_request(ffra_pkg::OP_NONE, 32'd0, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'd100, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'd0, 64'd0);
        issue_request(ffra_pkg::OP_FREE, 32'd0, 64'd0);
        issue_request(ffra_pkg::OP_FREE, 32'd0, ALL_ONES);
    endtask

    task automatic test_basic_ops();
        logic [63:0] base;
        issue_request(ffra_pkg::OP_INIT, 32'd0, 64'd0);
        base = heap_base_addr;
        issue_request(ffra_pkg::OP_ALLOC, 32'd1, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'd4096, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'd4097, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'd0, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'hFFFF_FFFF, 64'd0);
        issue_request(ffra_pkg::OP_FREE, 32'd0, base);
        // Freeing a region that is already free leaves it free.
        issue_request(ffra_pkg::OP_FREE, 32'd0, base);
        issue_request(ffra_pkg::OP_FREE, 32'd0, 64'd0);
        issue_request(ffra_pkg::OP_FREE, 32'd0, base + 64'd1);
        issue_request(ffra_pkg::OP_FREE, 32'd0, ALL_ONES);
        issue_request(ffra_pkg::OP_ALLOC, 32'd4096, 64'd0);
        issue_request(ffra_pkg::OP_NONE, 32'hFFFF_FFFF, ALL_ONES);
    endtask

    task automatic test_config_extremes();
        // The largest image pushes the heap start past the top and wraps it.
        write_reg(ffra_pkg::REG_IMAGE_SIZE, 32'hFFFF_FFFF);
        write_reg(ffra_pkg::REG_HEAP_PAGES, 32'd0);
        issue_request(ffra_pkg::OP_INIT, 32'd0, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'd1, 64'd0);
        issue_request(ffra_pkg::OP_FREE, 32'd0, heap_base_addr);
        issue_request(ffra_pkg::OP_FREE, 32'd0, 64'd0);
        write_reg(ffra_pkg::REG_IMAGE_SIZE, 32'd0);
        write_reg(ffra_pkg::REG_HEAP_PAGES, 32'd1);
        issue_request(ffra_pkg::OP_INIT, 32'd0, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'd1, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'd1, 64'd0);
        write_reg(ffra_pkg::REG_IMAGE_SIZE, 32'd4095);
        write_reg(ffra_pkg::REG_HEAP_PAGES, 32'hFFFF_FFFF);
        issue_request(ffra_pkg::OP_INIT, 32'd0, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'hFFFF_FFFF, 64'd0);
        issue_request(ffra_pkg::OP_ALLOC, 32'h8000_0000, 64'd0);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(ffra_pkg::REG_IMAGE_SIZE, 32'd0);
        write_reg(ffra_pkg::REG_HEAP_PAGES, 32'd64);
        issue_request(ffra_pkg::OP_INIT, 32'd0, 64'd0);
        wait_idle();
        -> hold_off_ev;
        for (int i = 0; i < 12; i++)
            issue_request(ffra_pkg::OP_ALLOC, $urandom_range(1, 8192), 64'd0);
    endtask

    task automatic run_random_phase(int n, int send_pct, int recv_pct,
                                    logic [31:0] image, logic [31:0] heap_cfg);
        int          pick;
        int          idx;
        logic [31:0] bytes;
        logic [63:0] addr;
        write_reg(ffra_pkg::REG_IMAGE_SIZE, image);
        write_reg(ffra_pkg::REG_HEAP_PAGES, heap_cfg);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        issue_request(ffra_pkg::OP_INIT, 32'd0, 64'd0);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            // Re-init keeps the table short so scans stay quick.
            if (pick < 3 || tbl_count > 40) begin
                issue_request(ffra_pkg::OP_INIT, $urandom(), {$urandom(), $urandom()});
            end else if (pick < 50) begin
                if ($urandom_range(0, 9) == 0)
                    bytes = $urandom();
                else
                    bytes = $urandom_range(1, 8) * 4096 - $urandom_range(0, 4095);
                issue_request(ffra_pkg::OP_ALLOC, bytes, {$urandom(), $urandom()});
            end else if (pick < 85) begin
                idx = $urandom_range(0, tbl_count - 1);
                issue_request(ffra_pkg::OP_FREE, $urandom(), tbl_start[idx]);
            end else begin
                case ($urandom_range(0, 4))
                    0: issue_request(ffra_pkg::OP_ALLOC, 32'd0, {$urandom(), $urandom()});
                    1: issue_request(ffra_pkg::OP_NONE, $urandom(), {$urandom(), $urandom()});
                    2: issue_request(ffra_pkg::OP_FREE, $urandom(), {$urandom(), $urandom()});
                    3: begin
                        addr = heap_base_addr - 64'd1 - $urandom_range(0, 65535);
                        if (addr >= heap_base_addr)
                            addr = 64'd0;
                        issue_request(ffra_pkg::OP_FREE, $urandom(), addr);
                    end
                    default: begin
                        idx = $urandom_range(0, tbl_count - 1);
                        issue_request(ffra_pkg::OP_FREE, $urandom(), tbl_start[idx] + 64'd1);
                    end
                endcase
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wr_data    = '0;
        tbl_count      = 0;
        heap_base_addr = 64'd0;
        cfg_image      = 32'd0;
        cfg_heap_pages = 31'd262144;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        requests_sent  = 0;
        results_checked = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_before_init();
        test_basic_ops();
        test_config_extremes();
        test_backpressure();
        run_random_phase(135, 0, 0, 32'd0, 32'd262144);
        run_random_phase(135, 59, 0, $urandom(), $urandom_range(8, 200));
        run_random_phase(135, 0, 59, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        run_random_phase(135, 19, 19, $urandom_range(0, 8191), $urandom_range(1, 40));

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("Covered %0d request transfers and %0d result transfers",
                 requests_sent, results_checked);
        $display("Statuses seen: ok %0d, no space %0d, table full %0d, not found %0d,",
                 status_seen[ffra_pkg::ST_OK], status_seen[ffra_pkg::ST_NO_SPACE],
                 status_seen[ffra_pkg::ST_TABLE_FULL], status_seen[ffra_pkg::ST_NOT_FOUND]);
        $display("below heap %0d, zero request %0d",
                 status_seen[ffra_pkg::ST_BELOW_HEAP], status_seen[ffra_pkg::ST_ZERO_REQ]);
        if (fail_count == 0)
            $display("** first_fit_region_allocator: PASSED **");
        else
            $display("** first_fit_region_allocator: FAILED **");
        $finish;
    end

    initial begin
        #150_000_000;
        $display("Timeout with %0d results still outstanding", expected_regions.size());
        $display("** first_fit_region_allocator: FAILED **");
        $finish;
    end

endmodule
